// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, operation codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   // default geometry
   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // field widths of the channel items
   localparam int MODE_W  = 3;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 5;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // request item
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] push_value;
   } req_type;

   // response item
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] read_value;
      logic [FILL_W-1:0] fill_count;
   } rsp_type;

endpackage

// ----- rtl/deq_mem.sv -----
// ----------------------------------------------------------------------------
// deq_mem
// Single-port element store with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module deq_mem #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_W      = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] store_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer and element count, store address generation and the
// response register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_W      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  deq_pkg::req_type       req,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output deq_pkg::rsp_type       rsp,
   output logic                   mem_wr_en,
   output logic                   mem_rd_en,
   output logic [ADDR_W-1:0]      mem_addr,
   output logic [VALUE_WIDTH-1:0] mem_wr_data,
   input  logic [VALUE_WIDTH-1:0] mem_rd_data
);

   import deq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic              accept;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rd_sel_ff, rd_sel_in;
   logic              empty, full;
   logic [ADDR_W-1:0] head_next, head_prev, tail_idx, back_idx;
   logic [SW-1:0]     tail_sum, back_sum;
   logic [WORD_W-1:0] rd_word;
   logic [FILL_W-1:0] fill_word;

   // one item in flight in the response register; a new one enters as it leaves
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ring arithmetic, one compare and subtract each
   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= CW'(DEPTH));
   assign head_next = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign back_sum  = tail_sum - 1'b1;
   assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? ADDR_W'(tail_sum - SW'(DEPTH))
                                               : ADDR_W'(tail_sum);
   assign back_idx  = (back_sum >= SW'(DEPTH)) ? ADDR_W'(back_sum - SW'(DEPTH))
                                               : ADDR_W'(back_sum);

   // push word cut or widened to the element width
   generate
      if (VALUE_WIDTH <= WORD_W) begin : g_wr_narrow
         assign mem_wr_data = req.push_value[VALUE_WIDTH-1:0];
      end else begin : g_wr_wide
         assign mem_wr_data = {{(VALUE_WIDTH - WORD_W){1'b0}}, req.push_value};
      end
   endgenerate

   // operation decode
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_sel_in = 1'b0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      mem_addr  = head_ff;
      case (req.mode)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               mem_wr_en = accept;
               mem_addr  = head_prev;
               head_in   = head_prev;
               count_in  = count_ff + 1'b1;
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               mem_wr_en = accept;
               mem_addr  = tail_idx;
               count_in  = count_ff + 1'b1;
            end
         end
         MODE_POP_FRONT, MODE_PEEK_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               mem_rd_en = accept;
               rd_sel_in = 1'b1;
               mem_addr  = head_ff;
               if (req.mode == MODE_POP_FRONT) begin
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         MODE_POP_BACK, MODE_PEEK_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               mem_rd_en = accept;
               rd_sel_in = 1'b1;
               mem_addr  = back_idx;
               if (req.mode == MODE_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         MODE_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // pointer, count and response control
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // read word and fill count fitted to the item fields
   generate
      if (VALUE_WIDTH >= WORD_W) begin : g_rd_wide
         assign rd_word = mem_rd_data[WORD_W-1:0];
      end else begin : g_rd_narrow
         assign rd_word = {{(WORD_W - VALUE_WIDTH){1'b0}}, mem_rd_data};
      end
      if (CW >= FILL_W) begin : g_fill_wide
         assign fill_word = count_ff[FILL_W-1:0];
      end else begin : g_fill_narrow
         assign fill_word = {{(FILL_W - CW){1'b0}}, count_ff};
      end
   endgenerate

   assign rsp_valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.read_value = rd_sel_ff ? rd_word : '0;
   assign rsp.fill_count = fill_word;

endmodule

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// A double-ended queue of DEPTH words held in a ring buffer. Each item is one
// operation: push front or back, pop front or back, peek front or back, or
// clear. Every item gives exactly one result item with a status, the word
// read at the addressed end (zero unless a pop or peek succeeded) and the
// fill count after the operation. One item is taken per cycle while the
// receiver does not stall a held result, and each result appears on the cycle
// after acceptance; the limit is the single port of the element store, which
// each operation uses at most once. A push on a full queue reports full and a
// pop or peek on an empty one reports empty, both leaving the queue as it was.
// Clear takes effect at once, with no sweep of the store.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH       = deq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp
);

   import deq_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic [VALUE_WIDTH-1:0] mem_rd_data;

   // pointers, count and response register
   deq_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // element store
   deq_mem #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // an accepted item always shows a result on the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   // a clear leaves the queue empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req.mode == MODE_CLEAR) |=>
      (rsp.fill_count == '0 && rsp.status == ST_OK))
      else $error("clear did not empty the queue");

   // a failed operation returns no word
   a_error_no_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_OK) |-> (rsp.read_value == '0))
      else $error("error result carries a read word");

   // the store is never written and read in the same cycle
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("store written and read together");

endmodule

// ----- tb/tb_double_ended_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer double-ended queue. A behavioural
// copy of the queue predicts the result of every accepted item. A checker
// compares each result item, field by field, with the oldest prediction.
// The stimulus covers directed corner cases, a fill-and-wrap sequence, a long
// receiver hold-off and random traffic that walks between empty and full,
// with idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int QDEPTH = DEPTH_DEFAULT;
   localparam int IDX_W  = $clog2(QDEPTH);
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   // predicted queue contents
   logic [WORD_W-1:0] ring_words [QDEPTH];
   logic [IDX_W-1:0]  ring_head;
   logic [FILL_W-1:0] ring_fill;

   rsp_type pending_results [$];
   rsp_type oldest;
   int      error_count;
   int      items_sent;
   int      results_seen;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_left;

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req           = '0;
      rsp_stall     = 1'b0;
      ring_head     = '0;
      ring_fill     = '0;
      error_count   = 0;
      items_sent    = 0;
      results_seen  = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 0;
   end

   always #5 clock = ~clock;

   // run-away guard
   initial begin
      #2000000;
      $display("tb_double_ended_queue: errors");
      $finish;
   end

   // apply one operation to the predicted queue and give its result
   function automatic rsp_type apply_op(input req_type op);
      rsp_type          res;
      logic [IDX_W-1:0] slot;
      res = '0;
      res.status = ST_OK;
      case (op.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (ring_fill == QDEPTH) begin
               res.status = ST_FULL;
            end else if (op.mode == MODE_PUSH_FRONT) begin
               ring_head = ring_head - 1'b1;
               ring_words[ring_head] = op.push_value;
               ring_fill = ring_fill + 1'b1;
            end else begin
               slot = ring_head + ring_fill[IDX_W-1:0];
               ring_words[slot] = op.push_value;
               ring_fill = ring_fill + 1'b1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
            if (ring_fill == 0) begin
               res.status = ST_EMPTY;
            end else if (op.mode == MODE_POP_FRONT || op.mode == MODE_PEEK_FRONT) begin
               res.read_value = ring_words[ring_head];
               if (op.mode == MODE_POP_FRONT) begin
                  ring_head = ring_head + 1'b1;
                  ring_fill = ring_fill - 1'b1;
               end
            end else begin
               // back element sits one below head plus fill, modulo depth
               slot = ring_head + ring_fill[IDX_W-1:0] - 1'b1;
               res.read_value = ring_words[slot];
               if (op.mode == MODE_POP_BACK) ring_fill = ring_fill - 1'b1;
            end
         end
         MODE_CLEAR: begin
            ring_head = '0;
            ring_fill = '0;
         end
         default: begin
         end
      endcase
      res.fill_count = ring_fill;
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // weighted towards pushes while growing, towards pops while shrinking
   function automatic req_type random_op(input bit grow);
      req_type op;
      int      r;
      r = $urandom_range(99);
      op.push_value = random_word();
      if (grow) begin
         if      (r < 30) op.mode = MODE_PUSH_FRONT;
         else if (r < 60) op.mode = MODE_PUSH_BACK;
         else if (r < 72) op.mode = MODE_POP_FRONT;
         else if (r < 84) op.mode = MODE_POP_BACK;
         else if (r < 90) op.mode = MODE_PEEK_FRONT;
         else if (r < 96) op.mode = MODE_PEEK_BACK;
         else if (r < 98) op.mode = MODE_CLEAR;
         else             op.mode = MODE_UNUSED;
      end else begin
         if      (r < 15) op.mode = MODE_PUSH_FRONT;
         else if (r < 30) op.mode = MODE_PUSH_BACK;
         else if (r < 53) op.mode = MODE_POP_FRONT;
         else if (r < 76) op.mode = MODE_POP_BACK;
         else if (r < 85) op.mode = MODE_PEEK_FRONT;
         else if (r < 94) op.mode = MODE_PEEK_BACK;
         else if (r < 96) op.mode = MODE_CLEAR;
         else             op.mode = MODE_UNUSED;
      end
      return op;
   endfunction

   // offer one item and wait until the block takes it
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
      req_type item;
      item.mode       = mode;
      item.push_value = value;
      @(negedge clock);
      req_valid = 1'b1;
      req       = item;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_op(item));
      items_sent++;
   endtask

   // optional idle stretch on the request side
   task automatic sender_gap();
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver idling, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item with nothing outstanding: %p", rsp);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp.status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp.status);
               error_count++;
            end
            if (rsp.read_value !== oldest.read_value) begin
               $error("read_value: expected %h, got %h", oldest.read_value, rsp.read_value);
               error_count++;
            end
            if (rsp.fill_count !== oldest.fill_count) begin
               $error("fill_count: expected %0d, got %0d", oldest.fill_count, rsp.fill_count);
               error_count++;
            end
         end
      end
   end

   // empty-queue errors, unused mode and a short push/pop round trip
   task automatic test_corner_cases();
      sender_gap(); send_item(MODE_POP_FRONT, '1);
      sender_gap(); send_item(MODE_POP_BACK, '0);
      sender_gap(); send_item(MODE_PEEK_FRONT, random_word());
      sender_gap(); send_item(MODE_PEEK_BACK, random_word());
      sender_gap(); send_item(MODE_UNUSED, '1);
      sender_gap(); send_item(MODE_PUSH_FRONT, '1);
      sender_gap(); send_item(MODE_PUSH_BACK, '0);
      sender_gap(); send_item(MODE_PEEK_FRONT, '0);
      sender_gap(); send_item(MODE_PEEK_BACK, '1);
      sender_gap(); send_item(MODE_POP_BACK, random_word());
      sender_gap(); send_item(MODE_POP_FRONT, random_word());
      drain();
   endtask

   // move the head, wrap it below zero, then hit full, pop and clear
   task automatic test_fill_and_wrap();
      int i;
      for (i = 0; i < 10; i++) begin
         sender_gap(); send_item(MODE_PUSH_BACK, random_word());
      end
      for (i = 0; i < 6; i++) begin
         sender_gap(); send_item(MODE_POP_FRONT, random_word());
      end
      for (i = 0; i < 12; i++) begin
         sender_gap(); send_item(MODE_PUSH_FRONT, random_word());
      end
      sender_gap(); send_item(MODE_PUSH_FRONT, '1);
      sender_gap(); send_item(MODE_PUSH_BACK, '1);
      sender_gap(); send_item(MODE_PEEK_FRONT, random_word());
      sender_gap(); send_item(MODE_PEEK_BACK, random_word());
      sender_gap(); send_item(MODE_POP_BACK, random_word());
      sender_gap(); send_item(MODE_POP_BACK, random_word());
      sender_gap(); send_item(MODE_CLEAR, random_word());
      sender_gap(); send_item(MODE_PEEK_FRONT, random_word());
      sender_gap(); send_item(MODE_POP_BACK, random_word());
      drain();
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_back_pressure();
      int      i;
      req_type op;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 120;
      for (i = 0; i < 40; i++) begin
         op = random_op(1'b1);
         send_item(op.mode, op.push_value);
      end
      drain();
   endtask

   // random traffic sweeping the fill level between empty and full
   task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
      int      i;
      bit      grow;
      req_type op;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      grow = 1'b1;
      for (i = 0; i < count; i++) begin
         sender_gap();
         op = random_op(grow);
         send_item(op.mode, op.push_value);
         if (ring_fill == QDEPTH)           grow = 1'b0;
         else if (ring_fill == 0)           grow = 1'b1;
         else if ($urandom_range(99) < 3)   grow = ~grow;
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 60;
      test_corner_cases();
      test_fill_and_wrap();
      test_random_traffic(590, 8, 60);
      test_random_traffic(590, 60, 8);
      test_random_traffic(590, 0, 0);
      test_back_pressure();

      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end
      $display("%0d items sent and %0d results checked across corner, wrap, random and",
               items_sent, results_seen);
      $display("back-pressure phases, %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("tb_double_ended_queue: clean");
      end else begin
         $display("tb_double_ended_queue: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/deq_pkg.sv
rtl/deq_mem.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
